[design/sss_pkg.sv]
`timescale 1ns / 1ps
package sss_pkg;

  localparam int DIGITS = 4;
  localparam int DIG_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // floor(v / 10) == (v * RECIP_10) >> RECIP_SH for every 16-bit v
  localparam logic [15:0] RECIP_10 = 16'd52429;
  localparam int RECIP_SH = 19;

  localparam logic [7:0] POINT_BIT = 8'h10;
  localparam logic [3:0] ALL_OFF = 4'hF;
  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_SHOW = 2'd1,
    ACT_SET  = 2'd2,
    ACT_FILL = 2'd3
  } action_t;

  // Work passed from front to back: either a scan tick or a masked digit write
  typedef struct packed {
    logic                    is_tick;
    logic [DIGITS-1:0]       mask;
    logic [DIGITS-1:0][7:0]  bytes;
  } cmd_t;

  function automatic logic [7:0] seg_encode(input logic [15:0] d);
    logic [7:0] s;
    begin
      s = 8'h00;
      if (d <= 16'd9) begin
        case (d[3:0])
          4'd0: s = 8'hee;
          4'd1: s = 8'h0a;
          4'd2: s = 8'he9;
          4'd3: s = 8'hab;
          4'd4: s = 8'h0f;
          4'd5: s = 8'ha7;
          4'd6: s = 8'he7;
          4'd7: s = 8'h8a;
          4'd8: s = 8'hef;
          4'd9: s = 8'haf;
          default: s = 8'h00;
        endcase
      end
      return s;
    end
  endfunction

endpackage

[design/sss_if.sv]
`timescale 1ns / 1ps
interface sss_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] value;
  logic [1:0]  digit_index;
  logic        point;

  modport source (output valid, action, value, digit_index, point, input ready);
  modport sink (input valid, action, value, digit_index, point, output ready);
endinterface

interface sss_out_if;
  logic       valid;
  logic       ready;
  logic       serial_bit;
  logic       latch_last;
  logic [3:0] digit_enables_n;

  modport source (output valid, serial_bit, latch_last, digit_enables_n, input ready);
  modport sink (input valid, serial_bit, latch_last, digit_enables_n, output ready);
endinterface

[design/sss_front.sv]
`timescale 1ns / 1ps
module sss_front (
  input  logic              clk,
  input  logic              rst_n,
  sss_in_if.sink            in_ch,
  input  logic              q_ready,
  output logic              q_push,
  output sss_pkg::cmd_t     q_data
);

  logic                                conv_r;
  logic [15:0]                         val_r;
  logic [sss_pkg::DIG_W-1:0]           cnt_r;
  logic [sss_pkg::DIGITS-1:0][7:0]     bytes_r;

  logic [31:0]                         prod;
  logic [15:0]                         quo;
  logic [15:0]                         quo10;
  logic [3:0]                          rem;
  logic [7:0]                          rem_seg;
  logic                                last_step;
  logic                                step_go;
  logic                                in_acc;
  logic [sss_pkg::DIGITS-1:0][7:0]     done_bytes;
  logic [7:0]                          set_byte;
  sss_pkg::action_t                    act;

  assign act = sss_pkg::action_t'(in_ch.action);

  // one decimal digit per cycle through a reciprocal multiply; the last waits for queue space
  assign prod    = 32'(val_r) * 32'(sss_pkg::RECIP_10);
  assign quo     = 16'(prod >> sss_pkg::RECIP_SH);
  assign quo10   = 16'((quo << 3) + (quo << 1));
  assign rem     = 4'(val_r - quo10);
  assign rem_seg = sss_pkg::seg_encode(16'(rem));

  assign last_step = conv_r && (cnt_r == '0);
  assign step_go   = conv_r && ((cnt_r != '0) || q_ready);

  assign in_ch.ready = !conv_r && q_ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    done_bytes    = bytes_r;
    done_bytes[0] = rem_seg;
  end

  always_comb begin
    set_byte = sss_pkg::seg_encode(in_ch.value);
    if (in_ch.point) begin
      set_byte = set_byte | sss_pkg::POINT_BIT;
    end
  end

  always_comb begin
    q_push  = 1'b0;
    q_data  = '0;
    if (last_step) begin
      q_push        = q_ready;
      q_data.mask   = '1;
      q_data.bytes  = done_bytes;
    end else if (in_acc) begin
      case (act)
        sss_pkg::ACT_TICK: begin
          q_push         = 1'b1;
          q_data.is_tick = 1'b1;
        end
        sss_pkg::ACT_SET: begin
          q_push       = 1'b1;
          q_data.mask  = sss_pkg::DIGITS'(1) << in_ch.digit_index;
          q_data.bytes = {sss_pkg::DIGITS{set_byte}};
        end
        sss_pkg::ACT_FILL: begin
          q_push       = 1'b1;
          q_data.mask  = '1;
          q_data.bytes = {sss_pkg::DIGITS{in_ch.value[7:0]}};
        end
        default: begin
          q_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_r <= 1'b0;
    end else if (in_acc && act == sss_pkg::ACT_SHOW) begin
      conv_r <= 1'b1;
    end else if (step_go && last_step) begin
      conv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && act == sss_pkg::ACT_SHOW) begin
      val_r <= in_ch.value;
      cnt_r <= sss_pkg::DIG_W'(sss_pkg::DIGITS - 1);
    end else if (step_go && !last_step) begin
      // least significant digit lands rightmost
      bytes_r[cnt_r] <= rem_seg;
      val_r          <= quo;
      cnt_r          <= cnt_r - 1'b1;
    end
  end

endmodule

[design/sss_queue.sv]
`timescale 1ns / 1ps
module sss_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sss_pkg::cmd_t     push_data,
  output logic              can_push,
  input  logic              pop,
  output logic              head_valid,
  output sss_pkg::cmd_t     head
);

  sss_pkg::cmd_t                  mem_r [sss_pkg::QDEPTH];
  logic [sss_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [sss_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [sss_pkg::QCNT_W-1:0]     cnt_r;

  assign can_push   = (cnt_r != sss_pkg::QCNT_W'(sss_pkg::QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == sss_pkg::QPTR_W'(sss_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == sss_pkg::QPTR_W'(sss_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> can_push)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue read while empty");

endmodule

[design/sss_back.sv]
`timescale 1ns / 1ps
module sss_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  sss_pkg::cmd_t     q_head,
  output logic              q_pop,
  sss_out_if.source         out_ch
);

  logic [sss_pkg::DIGITS-1:0][7:0]  seg_r;
  logic [sss_pkg::DIG_W-1:0]        pos_r;
  logic                             active_r;
  logic [2:0]                       bit_cnt_r;
  logic [7:0]                       shift_r;
  logic [3:0]                       en_r;

  logic                             out_vld_r;
  logic                             out_bit_r;
  logic                             out_latch_r;
  logic [3:0]                       out_en_r;

  logic                             out_load;
  logic                             last_load;
  logic                             tick_take;
  logic                             wr_take;
  logic [3:0]                       pos_ext;
  logic [3:0]                       en_nxt;

  assign out_load  = active_r && (!out_vld_r || out_ch.ready);
  assign last_load = out_load && (bit_cnt_r == sss_pkg::LAST_BIT);
  assign tick_take = q_valid && q_head.is_tick && (!active_r || last_load);
  assign wr_take   = q_valid && !q_head.is_tick;
  assign q_pop     = tick_take || wr_take;

  // digits past the fourth have no enable line
  assign pos_ext = 4'(pos_r);
  assign en_nxt  = (pos_ext < 4'd4) ? ~(4'b0001 << pos_ext[1:0]) : sss_pkg::ALL_OFF;

  assign out_ch.valid           = out_vld_r;
  assign out_ch.serial_bit      = out_bit_r;
  assign out_ch.latch_last      = out_latch_r;
  assign out_ch.digit_enables_n = out_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= '0;
      pos_r <= '0;
    end else if (wr_take) begin
      for (int d = 0; d < sss_pkg::DIGITS; d++) begin
        if (q_head.mask[d]) begin
          seg_r[d] <= q_head.bytes[d];
        end
      end
    end else if (tick_take) begin
      pos_r <= (pos_r == sss_pkg::DIG_W'(sss_pkg::DIGITS - 1)) ? '0 : pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      bit_cnt_r <= '0;
    end else if (tick_take) begin
      active_r  <= 1'b1;
      bit_cnt_r <= '0;
    end else if (out_load) begin
      bit_cnt_r <= bit_cnt_r + 1'b1;
      if (last_load) begin
        active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_take) begin
      shift_r <= seg_r[pos_r];
      en_r    <= en_nxt;
    end else if (out_load) begin
      shift_r <= shift_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bit_r   <= shift_r[0];
      out_latch_r <= (bit_cnt_r == sss_pkg::LAST_BIT);
      out_en_r    <= (bit_cnt_r == sss_pkg::LAST_BIT) ? en_r : sss_pkg::ALL_OFF;
    end
  end

  a_enables_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_latch_r) |-> (out_en_r == sss_pkg::ALL_OFF))
    else $error("digit enabled before latch bit");

  a_latch_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_ch.ready && out_latch_r) |=> !(out_vld_r && out_latch_r))
    else $error("two latch bits without shifting between them");

  a_tick_not_mid_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_take && active_r) |-> last_load)
    else $error("scan tick started while a byte is still shifting");

endmodule

[design/seven_segment_scan_shifter.sv]
`timescale 1ns / 1ps
// A scan tick passes the queue and the back's active flag before its first bit
// is registered out. A tick yields eight results, one per cycle while the output
// is ready; the next tick is taken with the last bit, and writes pop at once.
// Show number stalls input, one decimal digit per cycle; the last waits for room.
// Reset (synchronous, active low): all digits blank, scan at digit 0, queue empty.
module seven_segment_scan_shifter (
  input  logic       clk,
  input  logic       rst_n,
  sss_in_if.sink     in_ch,
  sss_out_if.source  out_ch
);

  logic           q_ready;
  logic           q_push;
  sss_pkg::cmd_t  q_data;
  logic           q_pop;
  logic           q_valid;
  sss_pkg::cmd_t  q_head;

  sss_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_data  (q_data)
  );

  sss_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .can_push   (q_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  sss_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
